### hw/rtl/serial_adc_capture_sequencer_top_assert.svh
// Assertion macros for the serial ADC capture sequencer.
// No dependencies; included by serial_adc_capture_sequencer_top.sv.
`ifndef SERIAL_ADC_CAPTURE_SEQUENCER_TOP_ASSERT_SVH
`define SERIAL_ADC_CAPTURE_SEQUENCER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// implication checked at every clock edge outside reset
`define SADC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked at the next clock edge
`define SADC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SADC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define SADC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### hw/rtl/sadc_seq_pkg.sv
// Package for the serial ADC capture sequencer: phase and register index codes,
// register reset values and the per-phase pin table. No dependencies.
package sadc_seq_pkg;

  localparam int unsigned TICK_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [TICK_W-1:0] tick_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_W_CONV  = 4'd1,
    PH_W_GAP   = 4'd2,
    PH_W_LO    = 4'd3,
    PH_W_HI    = 4'd4,
    PH_C_CONV  = 4'd5,
    PH_C_GAP   = 4'd6,
    PH_C_SETUP = 4'd7,
    PH_C_HI    = 4'd8,
    PH_C_LO    = 4'd9
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_EACH        = 3'd0,
    CFG_CONVERT_LOW       = 3'd1,
    CFG_CONVERT_TO_SELECT = 3'd2,
    CFG_SELECT_SETUP      = 3'd3,
    CFG_CLOCK_HALF        = 3'd4,
    CFG_WAKE_CLOCK_HALF   = 3'd5
  } cfg_idx_e;

  localparam logic  RST_RESET_EACH        = 1'b1;
  localparam tick_t RST_CONVERT_LOW       = 16'd10;
  localparam tick_t RST_CONVERT_TO_SELECT = 16'd20;
  localparam tick_t RST_SELECT_SETUP      = 16'd5;
  localparam tick_t RST_CLOCK_HALF        = 16'd274;
  localparam tick_t RST_WAKE_CLOCK_HALF   = 16'd25;

  typedef struct packed {
    logic convert;
    logic select;
    logic clock;
  } pins_t;

  function automatic pins_t phase_pins(phase_e p);
    pins_t pins;
    pins = '{convert: 1'b1, select: 1'b1, clock: 1'b0};
    case (p)
      PH_W_CONV, PH_C_CONV: pins.convert = 1'b0;
      PH_W_LO, PH_C_SETUP, PH_C_LO: pins.select = 1'b0;
      PH_W_HI, PH_C_HI: begin
        pins.select = 1'b0;
        pins.clock  = 1'b1;
      end
      default: pins = '{convert: 1'b1, select: 1'b1, clock: 1'b0};
    endcase
    return pins;
  endfunction

endpackage

### hw/rtl/serial_adc_capture_sequencer_top.sv
// Serial ADC capture sequencer: tick-driven master for a serial converter.
// Depends on sadc_seq_pkg and serial_adc_capture_sequencer_top_assert.svh.
//
// Usage: every request on the input channel is one timing tick carrying
// start_req, sample_count and the sampled data pin level. Each request gives
// exactly one result: the pin levels for that tick, a finished sample with its
// index and packet/capture marks when one completes, and the busy flag.
// A start with a nonzero count while idle begins a capture of up to
// MAX_SAMPLES samples; a start while busy or with count zero is ignored.
// Write timing registers through the cfg port only while no tick is in flight;
// the block does not enforce this. Each result appears in the cycle after its
// request is taken. Throughput: one request per cycle while in_stall_o is low,
// set by the single result register after the phase/timer update logic.
// Reset clears the sequencer to idle, the result register to empty and the
// timing registers to their defaults. While the result register is full and
// out_stall_i is high, in_stall_o is raised and the sequencer holds its state.
`include "serial_adc_capture_sequencer_top_assert.svh"

module serial_adc_capture_sequencer_top #(
  parameter int unsigned MAX_SAMPLES    = 2048,
  parameter int unsigned SAMPLE_BITS    = 12,
  parameter int unsigned PACKET_SAMPLES = 256,
  parameter int unsigned WAKE_CLOCKS    = 4,
  localparam int unsigned IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sadc_seq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sadc_seq_pkg::TICK_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                start_req_i,
  input  logic [15:0]                         sample_count_i,
  input  logic                                data_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                convert_pin_o,
  output logic                                select_pin_o,
  output logic                                clock_pin_o,
  output logic                                sample_valid_o,
  output logic [SAMPLE_BITS-1:0]              sample_value_o,
  output logic [IDX_W-1:0]                    sample_index_o,
  output logic                                packet_last_o,
  output logic                                capture_last_o,
  output logic                                busy_res_o
);
  import sadc_seq_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned BIT_W = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;
  localparam int unsigned WK_W  = (WAKE_CLOCKS > 1) ? $clog2(WAKE_CLOCKS) : 1;
  localparam int unsigned PKT_W = (PACKET_SAMPLES > 1) ? $clog2(PACKET_SAMPLES) : 1;

  logic  reset_each_q;
  tick_t convert_low_q, convert_to_select_q, select_setup_q, clock_half_q;
  tick_t wake_clock_half_q;

  phase_e                 phase_q, phase_d;
  tick_t                  tick_q, tick_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [WK_W-1:0]        wake_q, wake_d;
  logic [SAMPLE_BITS-1:0] shift_q, shift_d;
  logic [CNT_W-1:0]       idx_q, idx_d, target_q, target_d;
  logic [PKT_W-1:0]       pkt_q, pkt_d;

  logic                   out_valid_q;
  pins_t                  pins_q;
  logic                   sample_valid_q, packet_last_q, capture_last_q, busy_q;
  logic [SAMPLE_BITS-1:0] sample_value_q;
  logic [IDX_W-1:0]       sample_index_q;

  logic                   in_acc;
  tick_t                  len_raw, len;
  logic                   tick_done, bit_last, wake_last, pkt_wrap, cap_last, sample_done;
  logic [CNT_W-1:0]       idx_inc, start_n;
  logic [SAMPLE_BITS:0]   shift_ext;
  phase_e                 first_ph;
  pins_t                  pins_d;
  logic                   sample_valid_d, packet_last_d, capture_last_d;
  logic [SAMPLE_BITS-1:0] sample_value_d;
  logic [IDX_W-1:0]       sample_index_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_each_q        <= RST_RESET_EACH;
      convert_low_q       <= RST_CONVERT_LOW;
      convert_to_select_q <= RST_CONVERT_TO_SELECT;
      select_setup_q      <= RST_SELECT_SETUP;
      clock_half_q        <= RST_CLOCK_HALF;
      wake_clock_half_q   <= RST_WAKE_CLOCK_HALF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RESET_EACH:        reset_each_q        <= cfg_wdata_i[0];
        CFG_CONVERT_LOW:       convert_low_q       <= cfg_wdata_i;
        CFG_CONVERT_TO_SELECT: convert_to_select_q <= cfg_wdata_i;
        CFG_SELECT_SETUP:      select_setup_q      <= cfg_wdata_i;
        CFG_CLOCK_HALF:        clock_half_q        <= cfg_wdata_i;
        CFG_WAKE_CLOCK_HALF:   wake_clock_half_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase_q)
      PH_W_CONV, PH_C_CONV: len_raw = convert_low_q;
      PH_W_GAP, PH_C_GAP:   len_raw = convert_to_select_q;
      PH_W_LO, PH_W_HI:     len_raw = wake_clock_half_q;
      PH_C_SETUP:           len_raw = select_setup_q;
      default:              len_raw = clock_half_q;
    endcase
  end

  assign len         = (len_raw == '0) ? tick_t'(1) : len_raw;
  assign tick_done   = ({1'b0, tick_q} + (TICK_W + 1)'(1)) >= {1'b0, len};
  assign bit_last    = bit_q == BIT_W'(SAMPLE_BITS - 1);
  assign wake_last   = wake_q == WK_W'(WAKE_CLOCKS - 1);
  assign pkt_wrap    = pkt_q == PKT_W'(PACKET_SAMPLES - 1);
  assign idx_inc     = idx_q + CNT_W'(1);
  assign cap_last    = idx_inc == target_q;
  assign sample_done = (phase_q == PH_C_LO) && tick_done && bit_last;
  assign first_ph    = reset_each_q ? PH_W_CONV : PH_C_CONV;
  assign shift_ext   = {shift_q, data_in_i};
  assign start_n     = (sample_count_i > 16'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                          : sample_count_i[CNT_W-1:0];

  // next state
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    wake_d   = wake_q;
    shift_d  = shift_q;
    idx_d    = idx_q;
    target_d = target_q;
    pkt_d    = pkt_q;
    if (phase_q == PH_IDLE) begin
      if (start_req_i && (sample_count_i != '0)) begin
        target_d = start_n;
        idx_d    = '0;
        pkt_d    = '0;
        tick_d   = '0;
        phase_d  = first_ph;
      end
    end else begin
      if ((phase_q == PH_C_HI) && (tick_q == '0)) begin
        shift_d = shift_ext[SAMPLE_BITS-1:0];
      end
      if (!tick_done) begin
        tick_d = tick_q + tick_t'(1);
      end else begin
        tick_d = '0;
        unique case (phase_q)
          PH_W_CONV: phase_d = PH_W_GAP;
          PH_W_GAP: begin
            wake_d  = '0;
            phase_d = PH_W_LO;
          end
          PH_W_LO: phase_d = PH_W_HI;
          PH_W_HI: begin
            wake_d  = wake_q + WK_W'(1);
            phase_d = wake_last ? PH_C_CONV : PH_W_LO;
          end
          PH_C_CONV: begin
            shift_d = '0;
            phase_d = PH_C_GAP;
          end
          PH_C_GAP: begin
            bit_d   = '0;
            phase_d = PH_C_SETUP;
          end
          PH_C_SETUP: phase_d = PH_C_HI;
          PH_C_HI:    phase_d = PH_C_LO;
          PH_C_LO: begin
            if (bit_last) begin
              bit_d   = '0;
              idx_d   = idx_inc;
              pkt_d   = pkt_wrap ? '0 : pkt_q + PKT_W'(1);
              phase_d = cap_last ? PH_IDLE : first_ph;
            end else begin
              bit_d   = bit_q + BIT_W'(1);
              phase_d = PH_C_HI;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // result fields
  always_comb begin
    pins_d         = phase_pins(phase_q);
    sample_valid_d = sample_done;
    sample_value_d = sample_done ? shift_q : '0;
    sample_index_d = sample_done ? idx_q[IDX_W-1:0] : '0;
    capture_last_d = sample_done && cap_last;
    packet_last_d  = sample_done && (cap_last || pkt_wrap);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      bit_q    <= '0;
      wake_q   <= '0;
      shift_q  <= '0;
      idx_q    <= '0;
      target_q <= '0;
      pkt_q    <= '0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      wake_q   <= wake_d;
      shift_q  <= shift_d;
      idx_q    <= idx_d;
      target_q <= target_d;
      pkt_q    <= pkt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pins_q         <= pins_d;
      sample_valid_q <= sample_valid_d;
      sample_value_q <= sample_value_d;
      sample_index_q <= sample_index_d;
      packet_last_q  <= packet_last_d;
      capture_last_q <= capture_last_d;
      busy_q         <= phase_q != PH_IDLE;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign convert_pin_o  = pins_q.convert;
  assign select_pin_o   = pins_q.select;
  assign clock_pin_o    = pins_q.clock;
  assign sample_valid_o = sample_valid_q;
  assign sample_value_o = sample_value_q;
  assign sample_index_o = sample_index_q;
  assign packet_last_o  = packet_last_q;
  assign capture_last_o = capture_last_q;
  assign busy_res_o     = busy_q;

  `SADC_ASSERT_IMPL(a_sample_in_read, clk_i, rst_ni, out_valid_o && sample_valid_o,
                    busy_res_o && !select_pin_o && !clock_pin_o && convert_pin_o,
                    "sample reported outside the read low half")
  `SADC_ASSERT_IMPL(a_last_marks, clk_i, rst_ni, out_valid_o && capture_last_o,
                    packet_last_o && sample_valid_o,
                    "capture end without packet end")
  `SADC_ASSERT_IMPL(a_idle_pins, clk_i, rst_ni, out_valid_o && !busy_res_o,
                    convert_pin_o && select_pin_o && !clock_pin_o && !sample_valid_o,
                    "pins not idle while not busy")
  `SADC_ASSERT_NEXT(a_end_to_idle, clk_i, rst_ni, in_acc && sample_done && cap_last,
                    phase_q == PH_IDLE,
                    "sequencer not idle after the last sample")

endmodule

### sim/tb_serial_adc_capture_sequencer_top.sv
`timescale 1ns / 100ps
// Testbench for serial_adc_capture_sequencer_top: sends timing ticks and register settings,
// mirrors the sequencer in a tracker class and checks every result in order.
// Depends on sadc_seq_pkg and the sequencer RTL.
module tb_serial_adc_capture_sequencer_top;
  import sadc_seq_pkg::*;

  localparam int unsigned MAX_SAMPLES    = 2048;
  localparam int unsigned SAMPLE_BITS    = 12;
  localparam int unsigned PACKET_SAMPLES = 256;
  localparam int unsigned WAKE_CLOCKS    = 4;
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int unsigned LONG_HOLD      = 60;
  localparam int unsigned PHASE_TICKS    = 110;
  localparam int unsigned CLAMP_SAMPLES  = 4;

  typedef struct packed {
    logic        convert;
    logic        select;
    logic        sclk;
    logic        sample_valid;
    logic [11:0] value;
    logic [10:0] index;
    logic        packet_last;
    logic        capture_last;
    logic        busy;
  } tick_out_t;

  typedef struct {
    logic  wake_each;
    tick_t conv_low;
    tick_t conv_to_sel;
    tick_t sel_setup;
    tick_t clk_half;
    tick_t wake_half;
  } timing_t;

  class capture_tracker;
    logic        wake_each;
    tick_t       conv_low, conv_to_sel, sel_setup, clk_half, wake_half;
    phase_e      ph;
    int unsigned tick_cnt, bit_cnt, wake_cnt, shift, cur_idx, target;
    tick_out_t   due_ticks[$];
    int unsigned errors, samples, captures;

    function new();
      wake_each   = 1'b1;
      conv_low    = 16'd10;
      conv_to_sel = 16'd20;
      sel_setup   = 16'd5;
      clk_half    = 16'd274;
      wake_half   = 16'd25;
      ph          = PH_IDLE;
      tick_cnt    = 0;
      bit_cnt     = 0;
      wake_cnt    = 0;
      shift       = 0;
      cur_idx     = 0;
      target      = 0;
      errors      = 0;
      samples     = 0;
      captures    = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, tick_t val);
      case (idx)
        CFG_RESET_EACH:        wake_each   = val[0];
        CFG_CONVERT_LOW:       conv_low    = val;
        CFG_CONVERT_TO_SELECT: conv_to_sel = val;
        CFG_SELECT_SETUP:      sel_setup   = val;
        CFG_CLOCK_HALF:        clk_half    = val;
        CFG_WAKE_CLOCK_HALF:   wake_half   = val;
        default: ;
      endcase
    endfunction

    function int unsigned phase_len(phase_e p);
      tick_t len;
      case (p)
        PH_W_CONV, PH_C_CONV: len = conv_low;
        PH_W_GAP, PH_C_GAP:   len = conv_to_sel;
        PH_W_LO, PH_W_HI:     len = wake_half;
        PH_C_SETUP:           len = sel_setup;
        default:              len = clk_half;
      endcase
      return (len == '0) ? 32'd1 : 32'(len);
    endfunction

    function void note_tick(logic start, logic [15:0] count, logic din);
      tick_out_t   r;
      int unsigned n;
      r         = '0;
      r.convert = !(ph inside {PH_W_CONV, PH_C_CONV});
      r.select  = !(ph inside {PH_W_LO, PH_W_HI, PH_C_SETUP, PH_C_HI, PH_C_LO});
      r.sclk    = ph inside {PH_W_HI, PH_C_HI};
      r.busy    = (ph != PH_IDLE);
      if (ph == PH_IDLE) begin
        n = (32'(count) > MAX_SAMPLES) ? MAX_SAMPLES : 32'(count);
        if (start && n != 0) begin
          target   = n;
          cur_idx  = 0;
          tick_cnt = 0;
          ph       = wake_each ? PH_W_CONV : PH_C_CONV;
          captures++;
        end
      end else begin
        if (ph == PH_C_HI && tick_cnt == 0) shift = ((shift << 1) | 32'(din)) & 32'hFFF;
        if (tick_cnt + 1 < phase_len(ph)) begin
          tick_cnt++;
        end else begin
          tick_cnt = 0;
          case (ph)
            PH_W_CONV: ph = PH_W_GAP;
            PH_W_GAP: begin
              wake_cnt = 0;
              ph       = PH_W_LO;
            end
            PH_W_LO: ph = PH_W_HI;
            PH_W_HI: begin
              wake_cnt = (wake_cnt + 1) & 32'h7;
              ph       = (wake_cnt >= WAKE_CLOCKS) ? PH_C_CONV : PH_W_LO;
            end
            PH_C_CONV: begin
              shift = 0;
              ph    = PH_C_GAP;
            end
            PH_C_GAP: begin
              bit_cnt = 0;
              ph      = PH_C_SETUP;
            end
            PH_C_SETUP: ph = PH_C_HI;
            PH_C_HI:    ph = PH_C_LO;
            PH_C_LO: begin
              bit_cnt = (bit_cnt + 1) & 32'h1F;
              if (bit_cnt >= SAMPLE_BITS) begin
                r.sample_valid = 1'b1;
                r.value        = shift[11:0];
                r.index        = cur_idx[10:0];
                cur_idx        = (cur_idx + 1) & 32'h1FFF;
                r.capture_last = (cur_idx >= target);
                r.packet_last  = r.capture_last || (cur_idx % PACKET_SAMPLES == 0);
                if (r.capture_last) ph = PH_IDLE;
                else ph = wake_each ? PH_W_CONV : PH_C_CONV;
                samples++;
              end else begin
                ph = PH_C_HI;
              end
            end
            default: ph = PH_IDLE;
          endcase
        end
      end
      due_ticks.push_back(r);
    endfunction

    function void compare(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_tick(tick_out_t got);
      tick_out_t want;
      if (due_ticks.size() == 0) begin
        errors++;
        $display("%0t: result with no tick pending, got %h", $time, got);
        return;
      end
      want = due_ticks.pop_front();
      compare("convert_pin", 12'(want.convert), 12'(got.convert));
      compare("select_pin", 12'(want.select), 12'(got.select));
      compare("clock_pin", 12'(want.sclk), 12'(got.sclk));
      compare("sample_valid", 12'(want.sample_valid), 12'(got.sample_valid));
      compare("sample_value", want.value, got.value);
      compare("sample_index", 12'(want.index), 12'(got.index));
      compare("packet_last", 12'(want.packet_last), 12'(got.packet_last));
      compare("capture_last", 12'(want.capture_last), 12'(got.capture_last));
      compare("busy_res", 12'(want.busy), 12'(got.busy));
    endfunction
  endclass

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = '0;
  tick_t                cfg_wdata_i    = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 start_req_i    = 1'b0;
  logic [15:0]          sample_count_i = '0;
  logic                 data_in_i      = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic                 convert_pin_o;
  logic                 select_pin_o;
  logic                 clock_pin_o;
  logic                 sample_valid_o;
  logic [11:0]          sample_value_o;
  logic [10:0]          sample_index_o;
  logic                 packet_last_o;
  logic                 capture_last_o;
  logic                 busy_res_o;

  capture_tracker tracker = new();

  int unsigned cycles        = 0;
  int unsigned ticks_sent    = 0;
  int unsigned settings      = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned stall_left    = 0;
  bit          idling_on     = 1'b0;

  serial_adc_capture_sequencer_top uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles", cycles);
      $display("serial_adc_capture_sequencer_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_tick({convert_pin_o, select_pin_o, clock_pin_o, sample_valid_o,
                          sample_value_o, sample_index_o, packet_last_o, capture_last_o,
                          busy_res_o});
    if (rst_ni && in_valid_i && !in_stall_o)
      tracker.note_tick(start_req_i, sample_count_i, data_in_i);
  end

  always @(posedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      stall_left   = LONG_HOLD;
    end else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_tick(logic start, logic [15:0] count, logic din);
    in_valid_i     <= 1'b1;
    start_req_i    <= start;
    sample_count_i <= count;
    data_in_i      <= din;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  task automatic idle_gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.due_ticks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, tick_t val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    tracker.set_reg(idx, val);
  endtask

  task automatic apply_timing(timing_t t);
    tick_t flag_word;
    flag_word    = 16'($urandom_range(0, 65535));
    flag_word[0] = t.wake_each;
    write_reg(CFG_RESET_EACH, flag_word);
    write_reg(CFG_CONVERT_LOW, t.conv_low);
    write_reg(CFG_CONVERT_TO_SELECT, t.conv_to_sel);
    write_reg(CFG_SELECT_SETUP, t.sel_setup);
    write_reg(CFG_CLOCK_HALF, t.clk_half);
    write_reg(CFG_WAKE_CLOCK_HALF, t.wake_half);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic run_random(int unsigned n, bit with_hold, bit with_pause);
    logic        start;
    logic        din;
    logic [15:0] count;
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_requests <= hold_requests + 1;
      if (with_pause && i == n / 2) drain_results();
      else if (idling_on && $urandom_range(0, 5) == 0) idle_gap();
      start = ($urandom_range(0, 5) == 0);
      din   = 1'($urandom_range(0, 1));
      pick  = $urandom_range(0, 19);
      if (!start) count = 16'($urandom_range(0, 65535));
      else if (pick < 3) count = 16'd0;
      else if (pick < 17) count = 16'($urandom_range(1, 4));
      else count = 16'($urandom_range(5, 30));
      send_tick(start, count, din);
    end
  endtask

  function automatic timing_t random_timing(logic wake_each, int unsigned top);
    timing_t t;
    t.wake_each   = wake_each;
    t.conv_low    = 16'($urandom_range(1, top));
    t.conv_to_sel = 16'($urandom_range(1, top));
    t.sel_setup   = 16'($urandom_range(1, top));
    t.clk_half    = 16'($urandom_range(1, top));
    t.wake_half   = 16'($urandom_range(1, top));
    return t;
  endfunction

  initial begin
    timing_t t;
    logic    din_level;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tick(1'b0, 16'hFFFF, 1'b1);
    send_tick(1'b1, 16'd0, 1'b1);
    send_tick(1'b0, 16'd0, 1'b0);
    send_tick(1'b1, 16'd2, 1'b0);
    send_tick(1'b1, 16'hFFFF, 1'b1);
    send_tick(1'b1, 16'd1, 1'b1);
    repeat (4) send_tick(1'b0, 16'h8001, 1'($urandom_range(0, 1)));
    drain_results();
    // zero lengths count as one tick; the running capture cuts its phase short
    t = '{1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    apply_timing(t);
    for (int i = 0; i < 12; i++) send_tick(1'b0, 16'd0, i[0]);

    drain_results();
    idling_on <= 1'b1;
    t = '{1'b0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
    apply_timing(t);
    run_random(PHASE_TICKS, 1'b0, 1'b0);

    drain_results();
    t = '{1'b1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
    apply_timing(t);
    run_random(PHASE_TICKS, 1'b1, 1'b0);

    drain_results();
    idling_on <= 1'b0;
    apply_timing(random_timing(1'b1, 3));
    run_random(PHASE_TICKS, 1'b0, 1'b1);

    drain_results();
    idling_on <= 1'b1;
    t = '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    apply_timing(t);
    run_random(60, 1'b0, 1'b0);

    drain_results();
    apply_timing(random_timing(1'($urandom_range(0, 1)), 4));
    run_random(PHASE_TICKS, 1'b1, 1'b0);

    drain_results();
    idling_on <= 1'b0;
    apply_timing(random_timing(1'b0, 2));
    run_random(PHASE_TICKS, 1'b0, 1'b0);

    // finish any open capture, then start a clamped capture at the fastest timing
    drain_results();
    t = '{1'b0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
    apply_timing(t);
    while (tracker.ph != PH_IDLE) begin
      repeat (16) send_tick(1'b0, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      drain_results();
    end
    din_level = 1'b0;
    send_tick(1'b1, 16'hFFFF, din_level);
    repeat (CLAMP_SAMPLES * (3 + 2 * SAMPLE_BITS)) begin
      if ($urandom_range(0, 7) == 0) din_level = ~din_level;
      send_tick(1'b0, 16'($urandom_range(0, 65535)), din_level);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("%0d ticks under %0d register settings, %0d captures, %0d samples checked",
             ticks_sent, settings, tracker.captures, tracker.samples);
    $display("closing capture asked for 65535 samples, clamped to %0d, first %0d followed",
             MAX_SAMPLES, CLAMP_SAMPLES);
    if (tracker.errors == 0) begin
      $display("serial_adc_capture_sequencer_top: match");
    end else begin
      $display("serial_adc_capture_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule
